// ===== design/usbds_pkg.sv =====
// shared types and constants for the usb descriptor scanner
package usbds_pkg;

    localparam int OFFSET_BITS   = 16;
    localparam int OUT_OFF_BITS  = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 9;

    localparam logic [7:0] IFACE_TYPE    = 8'd4;
    localparam logic [7:0] IFACE_MIN_LEN = 8'd9;
    localparam logic [8:0] FILTER_ANY    = 9'h1FF;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FILTER_MODE = 3'd0,
        CFG_WANT_TYPE   = 3'd1,
        CFG_WANT_IFNUM  = 3'd2,
        CFG_WANT_ALT    = 3'd3,
        CFG_WANT_CLASS  = 3'd4,
        CFG_WANT_SUBCL  = 3'd5,
        CFG_WANT_PROTO  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic       filter_mode;
        logic [7:0] want_type;
        logic [8:0] want_iface_number;
        logic [8:0] want_alt_setting;
        logic [8:0] want_class;
        logic [8:0] want_subclass;
        logic [8:0] want_protocol;
    } t_cfg;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] byte_count;
        logic [OFFSET_BITS-1:0] desc_start;
        logic [7:0]             desc_pos;
        logic [7:0]             desc_len;
        logic [7:0]             desc_kind;
        logic [39:0]            captured_fields;
        logic                   search_done;
    } t_scan_state;

    typedef struct packed {
        logic                    found;
        logic [OUT_OFF_BITS-1:0] match_offset;
        logic [7:0]              match_type;
        logic [7:0]              match_length;
        logic [7:0]              match_iface_number;
    } t_result;

endpackage

// ===== design/usbds_in_if.sv =====
// byte input channel of the usb descriptor scanner
interface usbds_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== design/usbds_out_if.sv =====
// result channel of the usb descriptor scanner
interface usbds_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] match_offset;
    logic [7:0]  match_type;
    logic [7:0]  match_length;
    logic [7:0]  match_iface_number;

    modport source (output valid, output found, output match_offset, output match_type,
                    output match_length, output match_iface_number, input ready);
    modport sink   (input valid, input found, input match_offset, input match_type,
                    input match_length, input match_iface_number, output ready);
endinterface

// ===== design/usb_descriptor_scanner.sv =====
// top level of the usb descriptor scanner: state, config registers, result register
// The scanner walks a USB descriptor chain arriving one byte per transaction on i_byte,
// with last_byte set on the final byte before the end bound, and gives exactly one
// transaction on o_res per stream: either the first matching descriptor (its offset
// from the stream start, type, length and, in interface mode, interface number) or
// found = 0 with all other fields 0. Mode 0 matches the descriptor type held in
// want_type; mode 1 matches interface descriptors of 9 bytes or more against five
// filters, where a filter value of -1 (0x1FF) accepts anything. The result comes out in
// the cycle after the byte that completes the descriptor, or the byte that shows a
// zero length, a descriptor running past the end or a lone trailing length byte.
// Bytes after a result are swallowed until last_byte. A byte is taken every cycle:
// its work is one pass of compare and counter logic between the scan state registers
// and a one-entry result register, so the input stalls only while that register holds
// a result that the sink has not taken. Configuration is written through i_cfg_we,
// i_cfg_idx and i_cfg_data and should change only while no stream is in flight.
module usb_descriptor_scanner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    usbds_in_if.sink                            i_byte,
    usbds_out_if.source                         o_res,
    input  logic                                i_cfg_we,
    input  logic [usbds_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [usbds_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    usbds_pkg::t_cfg        r_cfg;
    usbds_pkg::t_scan_state r_state;
    usbds_pkg::t_scan_state n_state;
    usbds_pkg::t_result     r_res;
    usbds_pkg::t_result     n_res;
    logic                   r_res_valid;
    logic                   step_res_valid;
    logic                   in_ready;
    logic                   in_take;

    // the result register frees up in the same cycle it is drained
    assign in_ready = !r_res_valid || o_res.ready;
    assign in_take  = i_byte.valid && in_ready;
    assign i_byte.ready = in_ready;

    usbds_step u_step (
        .i_state      (r_state),
        .i_cfg        (r_cfg),
        .i_data_byte  (i_byte.data_byte),
        .i_last_byte  (i_byte.last_byte),
        .o_next_state (n_state),
        .o_res_valid  (step_res_valid),
        .o_result     (n_res)
    );

    // configuration registers, reset to mode 0, type 4 and all filters open
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_mode       <= 1'b0;
            r_cfg.want_type         <= usbds_pkg::IFACE_TYPE;
            r_cfg.want_iface_number <= usbds_pkg::FILTER_ANY;
            r_cfg.want_alt_setting  <= usbds_pkg::FILTER_ANY;
            r_cfg.want_class        <= usbds_pkg::FILTER_ANY;
            r_cfg.want_subclass     <= usbds_pkg::FILTER_ANY;
            r_cfg.want_protocol     <= usbds_pkg::FILTER_ANY;
        end else if (i_cfg_we) begin
            case (usbds_pkg::t_cfg_idx'(i_cfg_idx))
                usbds_pkg::CFG_FILTER_MODE: r_cfg.filter_mode       <= i_cfg_data[0];
                usbds_pkg::CFG_WANT_TYPE:   r_cfg.want_type         <= i_cfg_data[7:0];
                usbds_pkg::CFG_WANT_IFNUM:  r_cfg.want_iface_number <= i_cfg_data;
                usbds_pkg::CFG_WANT_ALT:    r_cfg.want_alt_setting  <= i_cfg_data;
                usbds_pkg::CFG_WANT_CLASS:  r_cfg.want_class        <= i_cfg_data;
                usbds_pkg::CFG_WANT_SUBCL:  r_cfg.want_subclass     <= i_cfg_data;
                usbds_pkg::CFG_WANT_PROTO:  r_cfg.want_protocol     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // scan state advances once per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // one-entry result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (in_take && step_res_valid) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && step_res_valid) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid              = r_res_valid;
    assign o_res.found              = r_res.found;
    assign o_res.match_offset       = r_res.match_offset;
    assign o_res.match_type         = r_res.match_type;
    assign o_res.match_length       = r_res.match_length;
    assign o_res.match_iface_number = r_res.match_iface_number;

endmodule

// ===== design/usbds_step.sv =====
// next-state and result logic for one stream byte
module usbds_step (
    input  usbds_pkg::t_scan_state i_state,
    input  usbds_pkg::t_cfg        i_cfg,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_last_byte,
    output usbds_pkg::t_scan_state o_next_state,
    output logic                   o_res_valid,
    output usbds_pkg::t_result     o_result
);

    logic        start_desc;
    logic        do_emit;
    logic [7:0]  kind_n;
    logic [39:0] cap_n;
    logic        final_byte;
    logic        filt_ok;
    logic        match_m1;
    usbds_pkg::t_scan_state n_state;
    usbds_pkg::t_result     res;

    always_comb begin
        n_state    = i_state;
        res        = '0;
        start_desc = 1'b0;
        do_emit    = 1'b0;
        kind_n     = i_state.desc_kind;
        cap_n      = i_state.captured_fields;
        final_byte = ({1'b0, i_state.desc_pos} + 9'd1) == {1'b0, i_state.desc_len};
        filt_ok    = 1'b0;
        match_m1   = 1'b0;

        if (i_state.search_done) begin
            // result already given, drain until last
            if (i_last_byte) begin
                n_state = '0;
            end
        end else begin
            n_state.byte_count = i_state.byte_count + 1'b1;
            if (i_state.desc_pos == 8'd0) begin
                start_desc = 1'b1;
            end else if (i_state.desc_pos >= i_state.desc_len) begin
                // one-byte descriptor: byte is its type and the next length
                if (!i_cfg.filter_mode && i_data_byte == i_cfg.want_type) begin
                    do_emit                = 1'b1;
                    res.found              = 1'b1;
                    res.match_offset       = 16'(i_state.desc_start);
                    res.match_type         = i_data_byte;
                    res.match_length       = i_state.desc_len;
                end else begin
                    start_desc = 1'b1;
                end
            end else begin
                case (i_state.desc_pos)
                    8'd1:    kind_n        = i_data_byte;
                    8'd2:    cap_n[7:0]    = i_data_byte;
                    8'd3:    cap_n[15:8]   = i_data_byte;
                    8'd5:    cap_n[23:16]  = i_data_byte;
                    8'd6:    cap_n[31:24]  = i_data_byte;
                    8'd7:    cap_n[39:32]  = i_data_byte;
                    default: ;
                endcase
                n_state.desc_kind       = kind_n;
                n_state.captured_fields = cap_n;

                filt_ok = (i_cfg.want_iface_number == usbds_pkg::FILTER_ANY
                           || i_cfg.want_iface_number == {1'b0, cap_n[7:0]})
                       && (i_cfg.want_alt_setting == usbds_pkg::FILTER_ANY
                           || i_cfg.want_alt_setting == {1'b0, cap_n[15:8]})
                       && (i_cfg.want_class == usbds_pkg::FILTER_ANY
                           || i_cfg.want_class == {1'b0, cap_n[23:16]})
                       && (i_cfg.want_subclass == usbds_pkg::FILTER_ANY
                           || i_cfg.want_subclass == {1'b0, cap_n[31:24]})
                       && (i_cfg.want_protocol == usbds_pkg::FILTER_ANY
                           || i_cfg.want_protocol == {1'b0, cap_n[39:32]});
                match_m1 = kind_n == usbds_pkg::IFACE_TYPE
                        && i_state.desc_len >= usbds_pkg::IFACE_MIN_LEN && filt_ok;

                if (final_byte) begin
                    if ((!i_cfg.filter_mode && kind_n == i_cfg.want_type)
                        || (i_cfg.filter_mode && match_m1)) begin
                        do_emit          = 1'b1;
                        res.found        = 1'b1;
                        res.match_offset = 16'(i_state.desc_start);
                        res.match_type   = kind_n;
                        res.match_length = i_state.desc_len;
                        res.match_iface_number = i_cfg.filter_mode ? cap_n[7:0] : 8'd0;
                    end else begin
                        n_state.desc_pos = 8'd0;
                        do_emit          = i_last_byte;
                    end
                end else if (i_last_byte) begin
                    // descriptor runs past the end bound
                    do_emit = 1'b1;
                end else begin
                    n_state.desc_pos = i_state.desc_pos + 8'd1;
                end
            end

            if (start_desc) begin
                n_state.desc_start      = i_state.byte_count;
                n_state.desc_len        = i_data_byte;
                n_state.desc_kind       = 8'd0;
                n_state.captured_fields = '0;
                if (i_data_byte == 8'd0 || i_last_byte) begin
                    do_emit = 1'b1;
                end else begin
                    n_state.desc_pos = 8'd1;
                end
            end

            if (do_emit) begin
                if (i_last_byte) begin
                    n_state = '0;
                end else begin
                    n_state.search_done = 1'b1;
                end
            end
        end
    end

    assign o_next_state = n_state;
    assign o_res_valid  = do_emit;
    assign o_result     = res;

endmodule

// ===== design/usbds_checker.sv =====
// port-level checks for the usb descriptor scanner, bound to the top level
module usbds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_found,
    input logic [15:0] i_match_offset,
    input logic [7:0]  i_match_type,
    input logic [7:0]  i_match_length,
    input logic [7:0]  i_match_iface_number
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_found)
            && $stable(i_match_offset) && $stable(i_match_length))
        else $error("result changed while stalled");

    // a not-found result carries all zero fields
    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |-> i_match_offset == 16'd0 && i_match_type == 8'd0
            && i_match_length == 8'd0 && i_match_iface_number == 8'd0)
        else $error("not-found result with nonzero fields");

    // a match never reports a zero length descriptor
    a_found_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_found |-> i_match_length != 8'd0)
        else $error("match with zero length");

    // no byte is taken while an undrained result blocks the register
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !(i_out_valid && !i_out_ready))
        else $error("byte accepted while result register is blocked");

endmodule

bind usb_descriptor_scanner usbds_checker u_usbds_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_byte.valid),
    .i_in_ready           (i_byte.ready),
    .i_out_valid          (o_res.valid),
    .i_out_ready          (o_res.ready),
    .i_found              (o_res.found),
    .i_match_offset       (o_res.match_offset),
    .i_match_type         (o_res.match_type),
    .i_match_length       (o_res.match_length),
    .i_match_iface_number (o_res.match_iface_number)
);

// ===== verif/usbds_scan_sb_pkg.sv =====
// scoreboard for the usb descriptor scanner: byte-level predictor and result checker
package usbds_scan_sb_pkg;

    class usbds_scan_sb;
        usbds_pkg::t_cfg                   regs;
        logic [usbds_pkg::OFFSET_BITS-1:0] byte_count;
        logic [usbds_pkg::OFFSET_BITS-1:0] desc_start;
        logic [7:0]                        desc_pos;
        logic [7:0]                        desc_len;
        logic [7:0]                        desc_kind;
        logic [39:0]                       iface_fields;
        bit                                search_done;

        usbds_pkg::t_result pending_results[$];
        int                 errors;
        int                 n_scanned;
        int                 n_found;
        int                 n_absent;

        function new();
            regs.filter_mode       = 1'b0;
            regs.want_type         = usbds_pkg::IFACE_TYPE;
            regs.want_iface_number = usbds_pkg::FILTER_ANY;
            regs.want_alt_setting  = usbds_pkg::FILTER_ANY;
            regs.want_class        = usbds_pkg::FILTER_ANY;
            regs.want_subclass     = usbds_pkg::FILTER_ANY;
            regs.want_protocol     = usbds_pkg::FILTER_ANY;
            clear_stream();
        endfunction

        function void clear_stream();
            byte_count   = '0;
            desc_start   = '0;
            desc_pos     = '0;
            desc_len     = '0;
            desc_kind    = '0;
            iface_fields = '0;
            search_done  = 1'b0;
        endfunction

        function void write_reg(usbds_pkg::t_cfg_idx idx,
                                logic [usbds_pkg::CFG_DATA_BITS-1:0] value);
            case (idx)
                usbds_pkg::CFG_FILTER_MODE: regs.filter_mode       = value[0];
                usbds_pkg::CFG_WANT_TYPE:   regs.want_type         = value[7:0];
                usbds_pkg::CFG_WANT_IFNUM:  regs.want_iface_number = value;
                usbds_pkg::CFG_WANT_ALT:    regs.want_alt_setting  = value;
                usbds_pkg::CFG_WANT_CLASS:  regs.want_class        = value;
                usbds_pkg::CFG_WANT_SUBCL:  regs.want_subclass     = value;
                usbds_pkg::CFG_WANT_PROTO:  regs.want_protocol     = value;
                default: ;
            endcase
        endfunction

        function bit filter_ok(logic [8:0] filt, logic [7:0] b);
            return filt == usbds_pkg::FILTER_ANY || filt == {1'b0, b};
        endfunction

        function void push_result(bit hit, logic [usbds_pkg::OFFSET_BITS-1:0] off,
                                  logic [7:0] kind, logic [7:0] len, logic [7:0] ifnum,
                                  bit last);
            usbds_pkg::t_result r;
            r.found              = hit;
            r.match_offset       = hit ? usbds_pkg::OUT_OFF_BITS'(off) : '0;
            r.match_type         = hit ? kind : '0;
            r.match_length       = hit ? len : '0;
            r.match_iface_number = hit ? ifnum : '0;
            pending_results.push_back(r);
            if (hit) n_found++;
            else n_absent++;
            if (last) clear_stream();
            else search_done = 1'b1;
        endfunction

        // length byte of a new descriptor
        function void start_descriptor(logic [7:0] b, logic [usbds_pkg::OFFSET_BITS-1:0] off,
                                       bit last);
            desc_start   = off;
            desc_len     = b;
            desc_kind    = '0;
            iface_fields = '0;
            if (b == 8'd0 || last) push_result(1'b0, '0, '0, '0, '0, last);
            else desc_pos = 8'd1;
        endfunction

        function void scan_byte(logic [7:0] b, bit last);
            logic [usbds_pkg::OFFSET_BITS-1:0] off;
            bit                                hit;
            if (search_done) begin
                if (last) clear_stream();
                return;
            end
            n_scanned++;
            off        = byte_count;
            byte_count = byte_count + 1'b1;

            if (desc_pos == 8'd0) begin
                start_descriptor(b, off, last);
                return;
            end

            // one-byte descriptor: this byte is its type and the next length
            if (desc_pos >= desc_len) begin
                if (!regs.filter_mode && b == regs.want_type)
                    push_result(1'b1, desc_start, b, desc_len, '0, last);
                else
                    start_descriptor(b, off, last);
                return;
            end

            case (desc_pos)
                8'd1: desc_kind = b;
                8'd2: iface_fields[7:0]   = b;
                8'd3: iface_fields[15:8]  = b;
                8'd5: iface_fields[23:16] = b;
                8'd6: iface_fields[31:24] = b;
                8'd7: iface_fields[39:32] = b;
                default: ;
            endcase

            if (desc_pos + 8'd1 == desc_len) begin
                if (!regs.filter_mode) begin
                    if (desc_kind == regs.want_type) begin
                        push_result(1'b1, desc_start, desc_kind, desc_len, '0, last);
                        return;
                    end
                end else begin
                    hit = desc_kind == usbds_pkg::IFACE_TYPE
                        && desc_len >= usbds_pkg::IFACE_MIN_LEN
                        && filter_ok(regs.want_iface_number, iface_fields[7:0])
                        && filter_ok(regs.want_alt_setting, iface_fields[15:8])
                        && filter_ok(regs.want_class, iface_fields[23:16])
                        && filter_ok(regs.want_subclass, iface_fields[31:24])
                        && filter_ok(regs.want_protocol, iface_fields[39:32]);
                    if (hit) begin
                        push_result(1'b1, desc_start, desc_kind, desc_len,
                                    iface_fields[7:0], last);
                        return;
                    end
                end
                desc_pos = 8'd0;
                if (last) push_result(1'b0, '0, '0, '0, '0, 1'b1);
                return;
            end

            if (last) begin
                push_result(1'b0, '0, '0, '0, '0, 1'b1);
                return;
            end
            desc_pos = desc_pos + 8'd1;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 100) $display("[%0t] scanner result error: %s", $time, what);
        endtask

        task check_result(usbds_pkg::t_result got);
            usbds_pkg::t_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing pending (found=%0d offset=%0d)",
                                 got.found, got.match_offset));
                return;
            end
            want = pending_results.pop_front();
            if (got.found !== want.found)
                report($sformatf("found %0d, predicted %0d", got.found, want.found));
            if (got.match_offset !== want.match_offset)
                report($sformatf("match_offset %0d, predicted %0d",
                                 got.match_offset, want.match_offset));
            if (got.match_type !== want.match_type)
                report($sformatf("match_type %0h, predicted %0h",
                                 got.match_type, want.match_type));
            if (got.match_length !== want.match_length)
                report($sformatf("match_length %0d, predicted %0d",
                                 got.match_length, want.match_length));
            if (got.match_iface_number !== want.match_iface_number)
                report($sformatf("match_iface_number %0d, predicted %0d",
                                 got.match_iface_number, want.match_iface_number));
        endtask

        task final_check();
            while (pending_results.size() > 0) begin
                void'(pending_results.pop_front());
                report("predicted result never arrived");
            end
        endtask
    endclass

endpackage

// ===== verif/tb_usb_descriptor_scanner.sv =====
// testbench top: drives descriptor byte streams into the scanner and checks every result
module tb_usb_descriptor_scanner;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 4;     // result register is one stage deep, plus margin
    localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction at all
    localparam int ITEM_TARGET  = 650;   // byte transactions over the whole run
    localparam int MIN_PHASES   = 6;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [usbds_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [usbds_pkg::CFG_DATA_BITS-1:0] i_cfg_data;

    usbds_in_if  byte_if ();
    usbds_out_if res_if ();

    usb_descriptor_scanner DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (byte_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    usbds_scan_sb_pkg::usbds_scan_sb scan_sb = new();

    logic [7:0] stream_bytes[$];  // bytes of the stream being built or sent
    bit         tx_steady;        // sender runs without gaps
    bit         rx_free;          // result sink never stalls
    int         rx_run;           // cycles left in the current ready or stall run
    int         n_streams;
    int         n_settings;
    int         n_bytes;          // byte transactions seen

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // result sink: runs of ready and stalls, mostly short stalls with a few long ones
    always @(negedge i_clk) begin
        if (rx_run > 0) begin
            rx_run--;
        end else if (rx_free || $urandom_range(0, 2) != 0) begin
            res_if.ready = 1'b1;
            rx_run       = $urandom_range(0, 12);
        end else begin
            res_if.ready = 1'b0;
            rx_run       = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 2);
        end
    end

    // monitor: every byte transaction feeds the predictor, every result transaction is checked
    always @(posedge i_clk) begin
        usbds_pkg::t_result got;
        if (i_rst_n) begin
            if (byte_if.valid && byte_if.ready) begin
                n_bytes++;
                scan_sb.scan_byte(byte_if.data_byte, byte_if.last_byte);
            end
            if (res_if.valid && res_if.ready) begin
                got.found              = res_if.found;
                got.match_offset       = res_if.match_offset;
                got.match_type         = res_if.match_type;
                got.match_length       = res_if.match_length;
                got.match_iface_number = res_if.match_iface_number;
                scan_sb.check_result(got);
            end
        end
    end

    // watchdog: the run is hung once nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("usb_descriptor_scanner: mismatch");
        $finish;
    end

    // byte values lean toward the extremes
    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // field byte that usually satisfies the given filter
    function automatic logic [7:0] field_near(logic [8:0] filt);
        if (!filt[8] && $urandom_range(0, 3) != 0) return filt[7:0];
        return rand_byte();
    endfunction

    function automatic logic [8:0] rand_filter();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return usbds_pkg::FILTER_ANY;
        if (r == 4) return {1'b1, 8'($urandom_range(0, 255))};  // negative, mostly never matches
        return {1'b0, rand_byte()};
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_steady) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one byte transaction, after an optional gap; valid stays up until the next negedge
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            byte_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_if.valid     = 1'b1;
        byte_if.data_byte = b;
        byte_if.last_byte = last;
        do @(posedge i_clk); while (!byte_if.ready);
    endtask

    // hold the sender until every predicted result has been taken
    task automatic drain_results(input int extra);
        @(negedge i_clk);
        byte_if.valid = 1'b0;
        while (scan_sb.pending_results.size() > 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic play_stream(input int pause_at);
        for (int i = 0; i < stream_bytes.size(); i++) begin
            if (i == pause_at) drain_results(0);
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
        end
        n_streams++;
    endtask

    task automatic write_reg(input usbds_pkg::t_cfg_idx idx,
                             input logic [usbds_pkg::CFG_DATA_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        scan_sb.write_reg(idx, value);
    endtask

    // register setting of one phase: the first few are the corner settings
    task automatic load_config(input int phase);
        logic       mode;
        logic [7:0] wtype;
        logic [8:0] filt[5];
        mode  = 1'($urandom_range(0, 1));
        wtype = ($urandom_range(0, 2) == 0) ? usbds_pkg::IFACE_TYPE : rand_byte();
        foreach (filt[i]) filt[i] = rand_filter();
        case (phase)
            0: begin
                mode  = 1'b0;
                wtype = 8'h00;
            end
            1: begin
                mode  = 1'b0;
                wtype = 8'hFF;
            end
            2: begin
                mode = 1'b1;
                foreach (filt[i]) filt[i] = usbds_pkg::FILTER_ANY;
            end
            3: begin
                mode = 1'b1;
                foreach (filt[i]) filt[i] = 9'h000;
            end
            4: begin
                mode = 1'b1;
                foreach (filt[i]) filt[i] = 9'h0FF;
            end
            5: begin
                // negative filters other than any: nothing should pass
                mode = 1'b1;
                foreach (filt[i]) filt[i] = usbds_pkg::FILTER_ANY;
                filt[$urandom_range(0, 4)] = 9'h1FE;
                filt[$urandom_range(0, 4)] = 9'h100;
            end
            default: ;
        endcase
        write_reg(usbds_pkg::CFG_FILTER_MODE, {8'h00, mode});
        write_reg(usbds_pkg::CFG_WANT_TYPE, {1'b0, wtype});
        write_reg(usbds_pkg::CFG_WANT_IFNUM, filt[0]);
        write_reg(usbds_pkg::CFG_WANT_ALT, filt[1]);
        write_reg(usbds_pkg::CFG_WANT_CLASS, filt[2]);
        write_reg(usbds_pkg::CFG_WANT_SUBCL, filt[3]);
        write_reg(usbds_pkg::CFG_WANT_PROTO, filt[4]);
        n_settings++;
    endtask

    // well-formed descriptor chain with random content, sometimes cut short or with a
    // trailing length byte
    task automatic build_chain();
        int pick;
        int len;
        int cut;
        stream_bytes.delete();
        repeat ($urandom_range(1, 4)) begin
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
                // interface descriptor, fields mostly taken from the current filters
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 8) : $urandom_range(9, 12);
                stream_bytes.push_back(8'(len));
                for (int k = 1; k < len; k++) begin
                    case (k)
                        1: stream_bytes.push_back(($urandom_range(0, 7) == 0)
                                                  ? rand_byte() : usbds_pkg::IFACE_TYPE);
                        2: stream_bytes.push_back(field_near(scan_sb.regs.want_iface_number));
                        3: stream_bytes.push_back(field_near(scan_sb.regs.want_alt_setting));
                        5: stream_bytes.push_back(field_near(scan_sb.regs.want_class));
                        6: stream_bytes.push_back(field_near(scan_sb.regs.want_subclass));
                        7: stream_bytes.push_back(field_near(scan_sb.regs.want_protocol));
                        default: stream_bytes.push_back(rand_byte());
                    endcase
                end
            end else if (pick < 14) begin
                // plain descriptor, often of the wanted type
                len = $urandom_range(2, 10);
                stream_bytes.push_back(8'(len));
                stream_bytes.push_back(($urandom_range(0, 1) == 0) ? scan_sb.regs.want_type
                                                                   : rand_byte());
                repeat (len - 2) stream_bytes.push_back(rand_byte());
            end else if (pick < 16) begin
                // one-byte descriptor: its type doubles as the next length byte
                stream_bytes.push_back(8'd1);
                if ($urandom_range(0, 1) == 0) stream_bytes.push_back(scan_sb.regs.want_type);
            end else if (pick == 16) begin
                stream_bytes.push_back(8'd0);
            end else begin
                len = $urandom_range(2, 40);
                stream_bytes.push_back(8'(len));
                repeat (len - 1) stream_bytes.push_back(rand_byte());
            end
        end
        pick = $urandom_range(0, 9);
        if (pick < 2 && stream_bytes.size() > 1) begin
            cut = $urandom_range(1, (stream_bytes.size() > 6) ? 5 : stream_bytes.size() - 1);
            repeat (cut) void'(stream_bytes.pop_back());
        end else if (pick < 4) begin
            stream_bytes.push_back(rand_byte());
        end
    endtask

    task automatic build_noise();
        stream_bytes.delete();
        repeat ($urandom_range(1, 16)) stream_bytes.push_back(rand_byte());
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        byte_if.valid     = 1'b0;
        byte_if.data_byte = '0;
        byte_if.last_byte = 1'b0;
        res_if.ready      = 1'b0;
        tx_steady         = 1'b0;
        rx_free           = 1'b0;
        rx_run            = 0;
        n_streams         = 0;
        n_settings        = 1;
        n_bytes           = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed streams on the reset setting: type match only, wanted type 4
        // zero length gives not found at once, the rest of the stream is swallowed
        stream_bytes = '{8'h00, 8'h05};
        play_stream(-1);
        // lone trailing length byte after a non-matching descriptor
        stream_bytes = '{8'h02, 8'h01, 8'h07};
        play_stream(-1);
        // descriptor running past the end bound
        stream_bytes = '{8'h05, 8'h04, 8'hAA};
        play_stream(-1);
        // chain that ends exactly at the bound with no match
        stream_bytes = '{8'h02, 8'h09, 8'h03, 8'h05, 8'h00};
        play_stream(-1);
        // one-byte descriptor whose type byte matches
        stream_bytes = '{8'h01, 8'h04, 8'hFF};
        play_stream(-1);
        // match in the middle, later bytes ignored until last
        stream_bytes = '{8'h03, 8'h04, 8'h00, 8'hFF, 8'h80};
        play_stream(-1);

        // interface filters, all open; pause the sender mid-stream until drained
        drain_results(DRAIN_CYCLES);
        write_reg(usbds_pkg::CFG_FILTER_MODE, 9'd1);
        n_settings++;
        stream_bytes = '{8'h09, usbds_pkg::IFACE_TYPE, 8'h02, 8'h00, 8'h01, 8'h03, 8'h00,
                         8'h00, 8'hFF};
        play_stream(4);

        // random phases: a register setting, then a batch of chains and noise streams
        for (int phase = 0; phase < MIN_PHASES || n_bytes < ITEM_TARGET; phase++) begin
            drain_results(DRAIN_CYCLES);
            load_config(phase);
            rx_free = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 5)) begin
                if ($urandom_range(0, 4) == 0) build_noise();
                else build_chain();
                tx_steady = ($urandom_range(0, 4) == 0);
                play_stream(($urandom_range(0, 7) == 0)
                            ? $urandom_range(0, stream_bytes.size() - 1) : -1);
            end
        end

        drain_results(DRAIN_CYCLES);
        scan_sb.final_check();
        $display("run covered %0d streams, %0d bytes sent and %0d scanned, %0d register settings",
                 n_streams, n_bytes, scan_sb.n_scanned, n_settings);
        $display("%0d descriptors found, %0d streams without a match, %0d errors",
                 scan_sb.n_found, scan_sb.n_absent, scan_sb.errors);
        if (scan_sb.errors == 0)
            $display("usb_descriptor_scanner: match");
        else
            $display("usb_descriptor_scanner: mismatch");
        $finish;
    end

endmodule
